>>> src/psg_pkg.sv
// Shared constants, types and helper functions of the PSG register dump parser.
package psg_pkg;

  // Sizes of the counters and of the fixed header.
  localparam int FRAME_COUNT_BITS = 24;
  localparam int HEADER_BYTES     = 16;
  localparam int HPOS_W           = $clog2(HEADER_BYTES + 1);
  localparam int BYTE_CNT_W       = 24;
  localparam int FRAME_IDX_W      = 24;
  localparam int FRAMES_ADD_W     = 10;
  localparam int FRAME_SUM_W      =
      ((FRAME_COUNT_BITS > FRAMES_ADD_W) ? FRAME_COUNT_BITS : FRAMES_ADD_W) + 1;

  // Token and header byte codes.
  localparam logic [7:0] TOK_FRAME  = 8'hFF;
  localparam logic [7:0] TOK_SKIP   = 8'hFE;
  localparam logic [7:0] TOK_END    = 8'hFD;
  localparam logic [7:0] HDR_MARKER = 8'h1A;
  localparam logic [7:0] SIG_P      = 8'h50;
  localparam logic [7:0] SIG_S      = 8'h53;
  localparam logic [7:0] SIG_G      = 8'h47;
  localparam logic [7:0] MAX_REG    = 8'd15;

  // Parser phase.
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TOKEN,
    PH_REG,
    PH_SKIP,
    PH_DONE,
    PH_FAILED
  } phase_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_FRAMES,
    KIND_END,
    KIND_ERROR
  } kind_t;

  // One result word.
  typedef struct packed {
    kind_t                   kind;
    logic [3:0]              reg_index;
    logic [7:0]              reg_value;
    logic [FRAME_IDX_W-1:0]  frame_index;
    logic [FRAMES_ADD_W-1:0] frames_added;
    logic [BYTE_CNT_W-1:0]   consumed_bytes;
    logic                    last_of_run;
  } result_t;

  // Results of one byte handed from the parser to the result buffer.
  typedef struct packed {
    logic       valid;
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // Result buffer status seen by the parser.
  typedef struct packed {
    logic       space;
    logic [1:0] count;
  } buf_status_t;

  // Expected signature byte at header positions zero to two.
  function automatic logic [7:0] sig_byte(input logic [1:0] pos);
    logic [7:0] b;
    unique case (pos)
      2'd0:    b = SIG_P;
      2'd1:    b = SIG_S;
      default: b = SIG_G;
    endcase
    return b;
  endfunction

  // Frame counter addition that saturates at its all-ones value.
  function automatic logic [FRAME_COUNT_BITS-1:0] frame_sat_add(
      input logic [FRAME_COUNT_BITS-1:0] ft,
      input logic [FRAMES_ADD_W-1:0]     k);
    logic [FRAME_SUM_W-1:0]      s;
    logic [FRAME_COUNT_BITS-1:0] fmax;
    fmax = '1;
    s = FRAME_SUM_W'(ft) + FRAME_SUM_W'(k);
    if (s > FRAME_SUM_W'(fmax)) begin
      return fmax;
    end
    return FRAME_COUNT_BITS'(s);
  endfunction

  // Builds a result word; last_of_run is filled in later.
  function automatic result_t make_result(
      input kind_t                       kind,
      input logic [3:0]                  reg_index,
      input logic [7:0]                  reg_value,
      input logic [FRAME_COUNT_BITS-1:0] frame,
      input logic [FRAMES_ADD_W-1:0]     frames_added,
      input logic [BYTE_CNT_W-1:0]       consumed);
    result_t r;
    r.kind           = kind;
    r.reg_index      = reg_index;
    r.reg_value      = reg_value;
    r.frame_index    = FRAME_IDX_W'(frame);
    r.frames_added   = frames_added;
    r.consumed_bytes = consumed;
    r.last_of_run    = 1'b0;
    return r;
  endfunction

endpackage

>>> src/psg_if.sv
// Handshake channels of the PSG register dump parser: input bytes and result words.
interface psg_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface psg_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  reg_index;
  logic [7:0]  reg_value;
  logic [23:0] frame_index;
  logic [9:0]  frames_added;
  logic [23:0] consumed_bytes;
  logic        last_of_run;

  modport source (output valid, output kind, output reg_index, output reg_value,
                  output frame_index, output frames_added, output consumed_bytes,
                  output last_of_run, input ready);
  modport sink   (input valid, input kind, input reg_index, input reg_value,
                  input frame_index, input frames_added, input consumed_bytes,
                  input last_of_run, output ready);
endinterface

>>> src/psg_parser.sv
// Input register, parser state and the decode of one byte into up to two results.
module psg_parser (
  input  logic                  clk,
  input  logic                  rst,
  psg_byte_if.sink              dump,
  input  psg_pkg::buf_status_t  status,
  output psg_pkg::push_t        push
);
  import psg_pkg::*;

  // Input register.
  logic       in_valid;
  logic [7:0] in_data;
  logic       in_last;

  // Parser state.
  phase_t                      phase, phase_next;
  logic [HPOS_W-1:0]           hpos, hpos_next;
  logic [3:0]                  preg, preg_next;
  logic [FRAME_COUNT_BITS-1:0] frame_total, frame_total_next;
  logic [BYTE_CNT_W-1:0]       byte_count, byte_count_next;

  logic                  advance;
  logic [BYTE_CNT_W-1:0] bc_inc;
  logic                  step_emit, last_emit, bad, start;
  result_t               step_res, last_res;
  logic                  short_file;

  // The held word moves on once the result buffer is empty after this cycle.
  assign advance    = in_valid && status.space;
  assign dump.ready = !in_valid || status.space;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (dump.ready) begin
      in_valid <= dump.valid;
    end
    if (dump.valid && dump.ready) begin
      in_data <= dump.data_byte;
      in_last <= dump.is_last;
    end
  end

  // State registers advance with each decoded word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      hpos        <= '0;
      preg        <= '0;
      frame_total <= '0;
      byte_count  <= '0;
    end else if (advance) begin
      if (in_last) begin
        // After the final byte of a file the parser starts over for the next one.
        phase       <= PH_HEADER;
        hpos        <= '0;
        preg        <= '0;
        frame_total <= '0;
      end else begin
        phase       <= phase_next;
        hpos        <= hpos_next;
        preg        <= preg_next;
        frame_total <= frame_total_next;
      end
      byte_count  <= byte_count_next;
    end
  end

  assign bc_inc = (byte_count == '1) ? byte_count : byte_count + 1'b1;

  // Decode of the held byte against the current phase.
  always_comb begin
    phase_next       = phase;
    hpos_next        = hpos;
    preg_next        = preg;
    frame_total_next = frame_total;
    step_emit        = 1'b0;
    step_res         = '0;
    bad              = 1'b0;
    start            = 1'b0;

    unique case (phase)
      PH_HEADER: begin
        priority if (hpos < HPOS_W'(3)) begin
          bad = (in_data != sig_byte(hpos[1:0]));
        end else if (hpos == HPOS_W'(3)) begin
          bad = (in_data != HDR_MARKER);
        end else if (hpos == HPOS_W'(4) && in_data == TOK_FRAME) begin
          start = 1'b1;
        end else if (hpos >= HPOS_W'(HEADER_BYTES)) begin
          start = (in_data == TOK_FRAME);
          bad   = (in_data != TOK_FRAME);
        end else begin
          // The remaining header bytes are skipped without a check.
        end
        if (start) begin
          frame_total_next = frame_sat_add(frame_total, FRAMES_ADD_W'(1));
          step_emit        = 1'b1;
          step_res         = make_result(KIND_FRAMES, '0, '0, frame_total_next,
                                         FRAMES_ADD_W'(1), '0);
          phase_next       = PH_TOKEN;
        end else if (bad) begin
          step_emit  = 1'b1;
          step_res   = make_result(KIND_ERROR, '0, '0, frame_total, '0, bc_inc);
          phase_next = PH_FAILED;
        end else begin
          hpos_next = hpos + 1'b1;
        end
      end
      PH_TOKEN: begin
        priority if (in_data == TOK_FRAME) begin
          frame_total_next = frame_sat_add(frame_total, FRAMES_ADD_W'(1));
          step_emit        = 1'b1;
          step_res         = make_result(KIND_FRAMES, '0, '0, frame_total_next,
                                         FRAMES_ADD_W'(1), '0);
        end else if (in_data == TOK_SKIP) begin
          phase_next = PH_SKIP;
        end else if (in_data == TOK_END) begin
          step_emit  = 1'b1;
          step_res   = make_result(KIND_END, '0, '0, frame_total, '0, bc_inc);
          phase_next = PH_DONE;
        end else if (in_data <= MAX_REG) begin
          preg_next  = in_data[3:0];
          phase_next = PH_REG;
        end else begin
          // Any other byte is ignored.
        end
      end
      PH_REG: begin
        step_emit  = 1'b1;
        step_res   = make_result(KIND_WRITE, preg, in_data,
                                 (frame_total != '0) ? frame_total - 1'b1 : '0,
                                 '0, '0);
        phase_next = PH_TOKEN;
      end
      PH_SKIP: begin
        frame_total_next = frame_sat_add(frame_total, {in_data, 2'b00});
        step_emit        = 1'b1;
        step_res         = make_result(KIND_FRAMES, '0, '0, frame_total_next,
                                       {in_data, 2'b00}, '0);
        phase_next       = PH_TOKEN;
      end
      default: begin
      end
    endcase
  end

  // End of file check and return to the reset state.
  always_comb begin
    last_emit       = 1'b0;
    last_res        = '0;
    short_file      = (bc_inc <= BYTE_CNT_W'(HEADER_BYTES));
    byte_count_next = bc_inc;
    if (in_last) begin
      if (phase_next != PH_FAILED) begin
        if (phase_next == PH_HEADER || phase_next == PH_REG ||
            phase_next == PH_SKIP || short_file) begin
          last_emit = 1'b1;
          last_res  = make_result(KIND_ERROR, '0, '0, frame_total_next, '0, bc_inc);
        end else if (phase_next == PH_TOKEN) begin
          last_emit = 1'b1;
          last_res  = make_result(KIND_END, '0, '0, frame_total_next, '0, bc_inc);
        end
      end
      byte_count_next = '0;
    end
    last_res.last_of_run = 1'b1;
  end

  // Results of the held byte, in order, towards the result buffer.
  always_comb begin
    push.valid = advance;
    push.count = {1'b0, step_emit} + {1'b0, last_emit};
    if (step_emit) begin
      push.first             = step_res;
      push.first.last_of_run = !last_emit;
      push.second            = last_res;
    end else begin
      push.first  = last_res;
      push.second = last_res;
    end
  end

endmodule

>>> src/psg_res_buf.sv
// Two-word result buffer that decouples the parser from the result sink.
module psg_res_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  psg_pkg::push_t        push,
  output psg_pkg::buf_status_t  status,
  psg_result_if.source          result
);
  import psg_pkg::*;

  logic [1:0] count;
  result_t    slot0, slot1;
  logic       pop;

  assign pop = result.valid && result.ready;

  // Word count: a push always lands on a buffer that is empty after this cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push.valid) begin
      count <= push.count;
    end else if (pop) begin
      count <= count - 1'b1;
    end
  end

  // Payload slots; the second moves forward when the first is taken.
  always_ff @(posedge clk) begin
    if (push.valid) begin
      slot0 <= push.first;
      slot1 <= push.second;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  assign status.space = (count == 2'd0) || (count == 2'd1 && pop);
  assign status.count = count;

  // Head word drives the output channel.
  assign result.valid          = (count != 2'd0);
  assign result.kind           = slot0.kind;
  assign result.reg_index      = slot0.reg_index;
  assign result.reg_value      = slot0.reg_value;
  assign result.frame_index    = slot0.frame_index;
  assign result.frames_added   = slot0.frames_added;
  assign result.consumed_bytes = slot0.consumed_bytes;
  assign result.last_of_run    = slot0.last_of_run;

endmodule

>>> src/psg_register_dump_parser_core.sv
// Top level of the PSG register dump parser: byte decoder and result buffer.
//
//   channel   direction   word
//   dump      in          data_byte[7:0], is_last
//   result    out         kind, reg_index, reg_value, frame_index, frames_added,
//                         consumed_bytes, last_of_run
//
// A byte is held in the input register, is decoded, and its results are written into
// the output register pair. One byte is taken per cycle while each byte gives at
// most one result and the sink takes every word; a byte that gives two results
// holds the input until the second of its words is taken from the two-word buffer.
// Synchronous reset clears the handshake state and the parser state; a byte with
// is_last set also returns the parser to its reset state. A stalled sink stalls
// the input once the buffer holds words that would not drain this cycle.
module psg_register_dump_parser_core (
  input  logic          clk,
  input  logic          rst,
  psg_byte_if.sink      dump,
  psg_result_if.source  result
);
  import psg_pkg::*;

  push_t       push;
  buf_status_t status;

  // Byte decoder with its input register and state.
  psg_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .dump   (dump),
    .status (status),
    .push   (push)
  );

  // Output register pair.
  psg_res_buf u_res_buf (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .status (status),
    .result (result)
  );

`ifndef SYNTHESIS
  // Results are only pushed into a buffer that drains this cycle.
  assert property (@(posedge clk) disable iff (rst) push.valid |-> status.space)
    else $error("result push without buffer space");

  // A byte never yields more than two words.
  assert property (@(posedge clk) disable iff (rst) status.count != 2'd3)
    else $error("result buffer overflow");

  // The second result of a byte follows the first without a gap.
  assert property (@(posedge clk) disable iff (rst)
      (result.valid && result.ready && !result.last_of_run) |=> result.valid)
    else $error("second result of a byte missing");

  // Nothing is offered right after reset.
  assert property (@(posedge clk) $past(rst) |-> !result.valid)
    else $error("result valid after reset");
`endif

endmodule
